// File: hdl/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants of the sorted store with statistics.
// ----------------------------------------------------------------------------
package sss_pkg;

    // width of one stored number, raw two's complement fixed-point code
    localparam int VALUE_W = 32;

    // command selector
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

    // default number of cells
    localparam int DEF_DEPTH = 64;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic ins;  // insert the broadcast value into the chain
        logic rot;  // rotate the occupied part of the chain by one place
    } t_cell_ctl;

endpackage

// File: hdl/sss_cell.sv
// ----------------------------------------------------------------------------
// sss_cell
// One cell of the sorted chain: holds one entry, takes part in insertion
// and in the rotation used for read-out.
// ----------------------------------------------------------------------------
module sss_cell
    import sss_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic        [CNT_W-1:0]   i_count,
    input  logic signed [VALUE_W-1:0] i_new,
    input  logic signed [VALUE_W-1:0] i_left,
    input  logic                      i_left_shift,
    input  logic signed [VALUE_W-1:0] i_right,
    input  logic signed [VALUE_W-1:0] i_head,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_shift
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      w_occ;
    logic                      w_tail;

    // occupancy from the shared fill count
    assign w_occ  = MY_IDX < i_count;
    assign w_tail = MY_IDX == (i_count - CNT_W'(1));

    // cell moves up when empty or when its entry is above the new value
    assign o_shift = !w_occ || (r_value > i_new);

    // next entry
    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (i_left_shift) begin
                n_value = i_left;
            end else if (o_shift) begin
                n_value = i_new;
            end
        end else if (i_ctl.rot) begin
            n_value = w_tail ? i_head : i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// File: hdl/sss_div.sv
// ----------------------------------------------------------------------------
// sss_div
// Bit-serial restoring divider: signed sum by unsigned count, quotient
// truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sss_div
    import sss_pkg::*;
#(
    parameter int SUM_W = 38,
    parameter int CNT_W = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [SUM_W-1:0]   i_dividend,
    input  logic        [CNT_W-1:0]   i_divisor,
    output logic                      o_done,
    output logic signed [VALUE_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic              r_neg;
    logic [SUM_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic [CNT_W:0]    w_trial;
    logic              w_fit;

    // shift in the next dividend bit and try the subtraction
    assign w_trial = {r_rem, r_dvd[SUM_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend register collects the quotient bits from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_dvd <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[SUM_W-2:0], w_fit};
            r_rem <= w_fit ? CNT_W'(w_trial - {1'b0, r_dvs}) : w_trial[CNT_W-1:0];
        end
    end

    // the magnitude fits 32 bits, so the sign is applied on the low word
    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_dvd[VALUE_W-1:0]) : $signed(r_dvd[VALUE_W-1:0]);

endmodule

// File: hdl/sorted_store_with_stats.sv
// ----------------------------------------------------------------------------
// sorted_store_with_stats
// Sorted store of signed fixed-point numbers with count, min, max and mean.
// ----------------------------------------------------------------------------
// The store keeps up to DEPTH raw 32-bit two's complement codes in ascending
// order in a chain of cells; the fraction width does not matter to the logic.
// Commands arrive on the slave stream (tuser = command, tdata = value): clear,
// insert or dump. Clear and insert each give one word with the count, min,
// max and truncated mean; an insert into a full store is dropped and flagged
// in the master tuser. Dump gives one word per entry in ascending order with
// its index, tlast on the highest one, or a single all-zero word with tlast
// when empty. An accepted insert waits in a divide state while the bit-serial
// divider recomputes the mean; the cell chain itself takes the value as the
// command is accepted. Clear and a dropped insert skip the divider. During a
// dump the chain rotates one place per word sent. A new command is taken once
// the previous one has handed its last word to the output register.
// ----------------------------------------------------------------------------
module sorted_store_with_stats
    import sss_pkg::*;
#(
    parameter int DEPTH  = DEF_DEPTH,
    parameter int CNT_W  = $clog2(DEPTH + 1),
    parameter int IDX_W  = $clog2(DEPTH),
    parameter int SUM_W  = VALUE_W + $clog2(DEPTH),
    parameter int MDAT_W = (((4 * VALUE_W + IDX_W + CNT_W) + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // slave stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [31:0]       i_s_tdata,   // value[31:0]
    input  logic [1:0]        i_s_tuser,   // cmd[1:0]
    // master stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [MDAT_W-1:0] o_m_tdata,   // elem_value, elem_index, count,
                                           // min_value, max_value,
                                           // average_value, zero pad
    output logic              o_m_tlast,
    output logic              o_m_tuser    // dropped
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_DUMP = 2'd3;
    localparam int PAD_W = MDAT_W - (4 * VALUE_W + IDX_W + CNT_W);

    logic [1:0]                r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic signed [VALUE_W-1:0] r_min, n_min;
    logic signed [VALUE_W-1:0] r_max, n_max;
    logic signed [VALUE_W-1:0] r_avg, n_avg;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic                      r_drop, n_drop;
    logic                      r_div_start, n_div_start;

    logic                      r_ovalid, n_ovalid;
    logic signed [VALUE_W-1:0] r_o_elem, n_o_elem;
    logic [IDX_W-1:0]          r_o_idx, n_o_idx;
    logic                      r_o_last, n_o_last;
    logic [CNT_W-1:0]          r_o_count, n_o_count;
    logic signed [VALUE_W-1:0] r_o_min, n_o_min;
    logic signed [VALUE_W-1:0] r_o_max, n_o_max;
    logic signed [VALUE_W-1:0] r_o_avg, n_o_avg;
    logic                      r_o_drop, n_o_drop;

    logic                      w_accept;
    logic                      w_slot_free;
    logic                      w_full;
    logic                      w_dump_last;
    logic signed [VALUE_W-1:0] w_value;
    logic [CMD_W-1:0]          w_cmd;
    t_cell_ctl                 w_ctl;
    logic                      w_div_done;
    logic signed [VALUE_W-1:0] w_quotient;

    logic signed [VALUE_W-1:0] w_cell_val [DEPTH];
    logic                      w_cell_shift [DEPTH];

    assign w_cmd       = i_s_tuser;
    assign w_value     = $signed(i_s_tdata);
    assign o_s_tready  = r_state == ST_IDLE;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_slot_free = !r_ovalid || i_m_tready;
    assign w_full      = r_count == CNT_W'(DEPTH);
    assign w_dump_last = CNT_W'(r_idx) == (r_count - CNT_W'(1));

    // chain control
    assign w_ctl.ins = w_accept && (w_cmd == CMD_INSERT) && !w_full;
    assign w_ctl.rot = (r_state == ST_DUMP) && w_slot_free;

    // chain of cells, lowest entry in cell 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sss_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_new        (w_value),
            .i_left       ((g == 0) ? w_value : w_cell_val[(g == 0) ? 0 : g - 1]),
            .i_left_shift ((g == 0) ? 1'b0 : w_cell_shift[(g == 0) ? 0 : g - 1]),
            .i_right      (w_cell_val[(g == DEPTH - 1) ? 0 : g + 1]),
            .i_head       (w_cell_val[0]),
            .o_value      (w_cell_val[g]),
            .o_shift      (w_cell_shift[g])
        );
    end

    // mean of the stored entries
    sss_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // command sequencing and output word loading
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sum       = r_sum;
        n_min       = r_min;
        n_max       = r_max;
        n_avg       = r_avg;
        n_idx       = r_idx;
        n_drop      = r_drop;
        n_div_start = 1'b0;
        n_ovalid    = r_ovalid && !i_m_tready;
        n_o_elem    = r_o_elem;
        n_o_idx     = r_o_idx;
        n_o_last    = r_o_last;
        n_o_count   = r_o_count;
        n_o_min     = r_o_min;
        n_o_max     = r_o_max;
        n_o_avg     = r_o_avg;
        n_o_drop    = r_o_drop;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_drop = 1'b0;
                    case (w_cmd)
                        CMD_CLEAR: begin
                            n_count = '0;
                            n_sum   = '0;
                            n_min   = '0;
                            n_max   = '0;
                            n_avg   = '0;
                            n_state = ST_EMIT;
                        end
                        CMD_INSERT: begin
                            if (w_full) begin
                                n_drop  = 1'b1;
                                n_state = ST_EMIT;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                                n_sum   = r_sum + SUM_W'(w_value);
                                if (r_count == '0) begin
                                    n_min = w_value;
                                    n_max = w_value;
                                end else begin
                                    if (w_value < r_min) begin
                                        n_min = w_value;
                                    end
                                    if (w_value > r_max) begin
                                        n_max = w_value;
                                    end
                                end
                                n_div_start = 1'b1;
                                n_state     = ST_DIV;
                            end
                        end
                        CMD_DUMP: begin
                            n_idx   = '0;
                            n_state = (r_count == '0) ? ST_EMIT : ST_DUMP;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_avg   = w_quotient;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    n_ovalid  = 1'b1;
                    n_o_elem  = '0;
                    n_o_idx   = '0;
                    n_o_last  = 1'b1;
                    n_o_count = r_count;
                    n_o_min   = r_min;
                    n_o_max   = r_max;
                    n_o_avg   = r_avg;
                    n_o_drop  = r_drop;
                    n_state   = ST_IDLE;
                end
            end
            ST_DUMP: begin
                if (w_slot_free) begin
                    n_ovalid  = 1'b1;
                    n_o_elem  = w_cell_val[0];
                    n_o_idx   = r_idx;
                    n_o_last  = w_dump_last;
                    n_o_count = r_count;
                    n_o_min   = r_min;
                    n_o_max   = r_max;
                    n_o_avg   = r_avg;
                    n_o_drop  = 1'b0;
                    n_idx     = r_idx + IDX_W'(1);
                    if (w_dump_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and statistics registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_avg       <= '0;
            r_idx       <= '0;
            r_drop      <= 1'b0;
            r_div_start <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_min       <= n_min;
            r_max       <= n_max;
            r_avg       <= n_avg;
            r_idx       <= n_idx;
            r_drop      <= n_drop;
            r_div_start <= n_div_start;
            r_ovalid    <= n_ovalid;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        r_o_elem  <= n_o_elem;
        r_o_idx   <= n_o_idx;
        r_o_last  <= n_o_last;
        r_o_count <= n_o_count;
        r_o_min   <= n_o_min;
        r_o_max   <= n_o_max;
        r_o_avg   <= n_o_avg;
        r_o_drop  <= n_o_drop;
    end

    // master stream packing
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {PAD_W'(0), r_o_avg, r_o_max, r_o_min, r_o_count, r_o_idx, r_o_elem};
    assign o_m_tlast  = r_o_last;
    assign o_m_tuser  = r_o_drop;

endmodule
